// ===== rtl/sdbs_pkg.sv =====
// shared types and constants for the sigma-delta background subtractor
// no dependencies; used by sdbs_ram users and the top level by scoped names
`timescale 1ns / 1ps
`default_nettype none

package sdbs_pkg;

  // field widths
  localparam int unsigned PixW     = 8;
  localparam int unsigned IdxW     = 16;
  localparam int unsigned GainW    = 4;
  localparam int unsigned CfgW     = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned TargetW  = GainW + PixW;
  localparam int unsigned EntryW   = 2 * PixW;

  // register map of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN    = 2'd0,
    CFG_VAR_MIN = 2'd1,
    CFG_VAR_MAX = 2'd2,
    CFG_FG_CODE = 2'd3
  } cfg_idx_e;

  // register defaults
  localparam logic [GainW-1:0] GAIN_RST    = 4'd2;
  localparam logic [PixW-1:0]  VAR_MIN_RST = 8'd1;
  localparam logic [PixW-1:0]  VAR_MAX_RST = 8'd254;
  localparam logic [PixW-1:0]  FG_CODE_RST = 8'd255;

  // mode flag on the input tuser
  localparam logic MODE_UPDATE = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/sdbs_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// read-first on an address collision; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sdbs_ram #(
  parameter  int unsigned WIDTH = 16,
  parameter  int unsigned DEPTH = 65536,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [AddrW-1:0]       waddr_i,
  input  wire logic [WIDTH-1:0]       wdata_i,
  input  wire logic                   re_i,
  input  wire logic [AddrW-1:0]       raddr_i,
  output      logic [WIDTH-1:0]       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/sigma_delta_background_subtract.sv =====
// sigma-delta background subtractor, top level: pipeline, forwarding, output buffer
// depends on sdbs_pkg and sdbs_ram
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: pixel_index, pixel_value; tuser: mode
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: abs_difference, motion_mask
// cfg       in   cfg_we_i (no wait, no read)    cfg_idx_i, cfg_data_i
//
// one pixel beat per clock sustained while the output buffer has room; a result beat
// follows its pixel beat through the ram read issued on the accepting edge, then mean
// step, difference and gain product, variance step with store write-back
// read-modify-write hazards on the same pixel are resolved by forwarding from
// the later stages and a three-deep history of recent writes, so repeated
// indices need no bubbles
// the store is not cleared: every position must see an init beat before an
// update beat; reset clears only control state and config registers
// a two-beat output buffer decouples the pipe from m_axis_tready; when it is
// full the whole pipe holds and s_axis_tready is low

module sigma_delta_background_subtract #(
  parameter int unsigned FRAME_PIXELS = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [15:0] pixel_index, [23:16] pixel_value
  input  wire logic [0:0]  s_axis_tuser,   // [0] mode
  // master side
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata,   // [7:0] abs_difference, [15:8] motion_mask
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [sdbs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [sdbs_pkg::CfgW-1:0]     cfg_data_i
);

  localparam int unsigned PixW  = sdbs_pkg::PixW;
  localparam int unsigned IdxW  = sdbs_pkg::IdxW;
  localparam int unsigned TgtW  = sdbs_pkg::TargetW;
  localparam int unsigned EntW  = sdbs_pkg::EntryW;
  localparam int unsigned AW    = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int unsigned XW    = (AW > IdxW) ? AW : IdxW;
  localparam int unsigned CW    = 21;  // holds the largest frame size

  typedef struct packed {
    logic            valid;
    logic            wr;     // in frame, touches the store
    logic            upd;    // update beat, gives a result
    logic [AW-1:0]   addr;
    logic [PixW-1:0] pix;
  } s1_t;

  typedef struct packed {
    logic            valid;
    logic            wr;
    logic            upd;
    logic [AW-1:0]   addr;
    logic [PixW-1:0] pix;
    logic [PixW-1:0] mean;
    logic [PixW-1:0] var_raw;
  } s2_t;

  typedef struct packed {
    logic            valid;
    logic            wr;
    logic            upd;
    logic [AW-1:0]   addr;
    logic [PixW-1:0] mean;
    logic [PixW-1:0] var_raw;
    logic [PixW-1:0] diff;
    logic [TgtW-1:0] target;
  } s3_t;

  typedef struct packed {
    logic            valid;
    logic [AW-1:0]   addr;
    logic [PixW-1:0] mean;
    logic [PixW-1:0] vari;
  } wb_t;

  // config registers
  logic [sdbs_pkg::GainW-1:0] gain_q;
  logic [PixW-1:0]            vmin_q, vmax_q, fg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= sdbs_pkg::GAIN_RST;
      vmin_q <= sdbs_pkg::VAR_MIN_RST;
      vmax_q <= sdbs_pkg::VAR_MAX_RST;
      fg_q   <= sdbs_pkg::FG_CODE_RST;
    end else if (cfg_we_i) begin
      case (sdbs_pkg::cfg_idx_e'(cfg_idx_i))
        sdbs_pkg::CFG_GAIN:    gain_q <= cfg_data_i[sdbs_pkg::GainW-1:0];
        sdbs_pkg::CFG_VAR_MIN: vmin_q <= cfg_data_i;
        sdbs_pkg::CFG_VAR_MAX: vmax_q <= cfg_data_i;
        sdbs_pkg::CFG_FG_CODE: fg_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipe enable: everything moves together while the output buffer has room
  logic [1:0] cnt_q, cnt_d;
  logic       en;
  assign en            = (cnt_q != 2'd2);
  assign s_axis_tready = en;

  // input decode
  logic [IdxW-1:0] in_idx;
  logic [CW-1:0]   idx_wide;
  logic [XW-1:0]   idx_x;
  logic            in_frame;
  s1_t             s1_d, s1_q;

  assign in_idx   = s_axis_tdata[IdxW-1:0];
  assign idx_wide = CW'(in_idx);
  assign idx_x    = XW'(in_idx);
  assign in_frame = idx_wide < CW'(FRAME_PIXELS);

  always_comb begin
    s1_d.valid = s_axis_tvalid;
    s1_d.wr    = s_axis_tvalid && in_frame;
    s1_d.upd   = (s_axis_tuser[0] == sdbs_pkg::MODE_UPDATE);
    s1_d.addr  = idx_x[AW-1:0];
    s1_d.pix   = s_axis_tdata[IdxW+PixW-1:IdxW];
  end

  // store of {variance, mean} per pixel
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [EntW-1:0] ram_wdata, ram_rdata;

  sdbs_ram #(
    .WIDTH (EntW),
    .DEPTH (FRAME_PIXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (en),
    .raddr_i (s1_d.addr),
    .rdata_o (ram_rdata)
  );

  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  wb_t w_q [3];
  wb_t wb_d;

  // stage 1: pick the newest mean for this pixel, step it toward the pixel (init beats take the pixel)
  logic [PixW-1:0] m_sel;
  always_comb begin
    if (s2_q.valid && s2_q.wr && s2_q.addr == s1_q.addr) begin
      m_sel = s2_q.mean;
    end else if (s3_q.valid && s3_q.wr && s3_q.addr == s1_q.addr) begin
      m_sel = s3_q.mean;
    end else if (w_q[0].valid && w_q[0].addr == s1_q.addr) begin
      m_sel = w_q[0].mean;
    end else begin
      m_sel = ram_rdata[PixW-1:0];
    end

    s2_d.valid   = s1_q.valid;
    s2_d.wr      = s1_q.wr;
    s2_d.upd     = s1_q.upd;
    s2_d.addr    = s1_q.addr;
    s2_d.pix     = s1_q.pix;
    s2_d.var_raw = ram_rdata[EntW-1:PixW];
    if (!s1_q.upd) begin
      s2_d.mean = s1_q.pix;
    end else if (m_sel < s1_q.pix) begin
      s2_d.mean = m_sel + 8'd1;
    end else if (m_sel > s1_q.pix) begin
      s2_d.mean = m_sel - 8'd1;
    end else begin
      s2_d.mean = m_sel;
    end
  end

  // stage 2: absolute difference and variance target
  logic [PixW-1:0] diff;
  always_comb begin
    diff = (s2_q.mean > s2_q.pix) ? (s2_q.mean - s2_q.pix) : (s2_q.pix - s2_q.mean);

    s3_d.valid   = s2_q.valid;
    s3_d.wr      = s2_q.wr;
    s3_d.upd     = s2_q.upd;
    s3_d.addr    = s2_q.addr;
    s3_d.mean    = s2_q.mean;
    s3_d.var_raw = s2_q.var_raw;
    s3_d.diff    = diff;
    s3_d.target  = TgtW'(gain_q) * TgtW'(diff);
  end

  // stage 3: newest variance from the write history, step, clamp (init beats take the minimum), mask
  logic [PixW-1:0] v_sel;
  logic [PixW:0]   v_step, v_hi, v_lo;
  logic [PixW-1:0] v_new;
  logic [PixW-1:0] mask;
  logic            push;

  always_comb begin
    if (w_q[0].valid && w_q[0].addr == s3_q.addr) begin
      v_sel = w_q[0].vari;
    end else if (w_q[1].valid && w_q[1].addr == s3_q.addr) begin
      v_sel = w_q[1].vari;
    end else if (w_q[2].valid && w_q[2].addr == s3_q.addr) begin
      v_sel = w_q[2].vari;
    end else begin
      v_sel = s3_q.var_raw;
    end

    if (TgtW'(v_sel) < s3_q.target) begin
      v_step = {1'b0, v_sel} + 9'd1;
    end else if (TgtW'(v_sel) > s3_q.target) begin
      v_step = {1'b0, v_sel} - 9'd1;
    end else begin
      v_step = {1'b0, v_sel};
    end

    // upper clamp first, lower clamp wins when the bounds cross
    v_hi  = (v_step > {1'b0, vmax_q}) ? {1'b0, vmax_q} : v_step;
    v_lo  = (v_hi < {1'b0, vmin_q}) ? {1'b0, vmin_q} : v_hi;
    v_new = s3_q.upd ? v_lo[PixW-1:0] : vmin_q;
    mask  = (s3_q.diff < v_new) ? '0 : fg_q;

    wb_d.valid = s3_q.valid && s3_q.wr;
    wb_d.addr  = s3_q.addr;
    wb_d.mean  = s3_q.mean;
    wb_d.vari  = v_new;
  end

  assign ram_we    = en && wb_d.valid;
  assign ram_waddr = wb_d.addr;
  assign ram_wdata = {wb_d.vari, wb_d.mean};
  assign push      = en && s3_q.valid && s3_q.wr && s3_q.upd;

  // pipe registers, all stages move together under enable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      s2_q   <= '0;
      s3_q   <= '0;
      w_q[0] <= '0;
      w_q[1] <= '0;
      w_q[2] <= '0;
    end else if (en) begin
      s1_q   <= s1_d;
      s2_q   <= s2_d;
      s3_q   <= s3_d;
      w_q[0] <= wb_d;
      w_q[1] <= w_q[0];
      w_q[2] <= w_q[1];
    end
  end

  // two-beat output buffer, head in slot 0
  logic [15:0] ob_q [2];
  logic [15:0] ob_new;
  logic        pop;

  assign ob_new = {mask, s3_q.diff};
  assign pop    = m_axis_tvalid && m_axis_tready;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      ob_q[0] <= (cnt_q == 2'd2) ? ob_q[1] : ob_new;
    end else if (push && cnt_q == 2'd0) begin
      ob_q[0] <= ob_new;
    end
    if (push && ((cnt_q == 2'd1 && !pop) || (cnt_q == 2'd2))) begin
      ob_q[1] <= ob_new;
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = ob_q[0];

`ifndef SYNTHESIS
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (cnt_q != 2'd2))
    else $error("result pushed into a full output buffer");

  a_hist_tracks_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> (w_q[0].valid == $past(s3_q.valid && s3_q.wr)))
    else $error("write history lost a store write");

  a_pipe_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable({s1_q.valid, s2_q.valid, s3_q.valid, w_q[0].valid}))
    else $error("pipe moved while held");
`endif

endmodule

`default_nettype wire
